>>> design/mwts_pkg.sv
// mwts_pkg: types, constants and helper functions for the multi-window time switch
// no dependencies

package mwts_pkg;

  localparam int TOD_W     = 17;
  localparam int HM_SHIFT  = 6;
  localparam int HM_W      = TOD_W - HM_SHIFT;
  localparam int NUM_REGS  = 4;
  localparam int REG_W     = 35;
  localparam int REG_IDX_W = 2;

  typedef logic [TOD_W-1:0] tod_t;
  typedef logic [HM_W-1:0]  hm_t;

  typedef struct packed {
    logic enable;
    tod_t on_time;
    tod_t off_time;
  } window_t;

  typedef struct packed {
    logic output_on;
    logic switched_on;
    logic switched_off;
  } flags_t;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  // hour:minute only, wrap past midnight allowed
  function automatic logic in_window(tod_t now, tod_t start, tod_t stop);
    hm_t t;
    hm_t s;
    hm_t e;
    t = now[TOD_W-1:HM_SHIFT];
    s = start[TOD_W-1:HM_SHIFT];
    e = stop[TOD_W-1:HM_SHIFT];
    if (s <= e) begin
      return (t >= s) && (t <= e);
    end
    return (t >= s) || (t <= e);
  endfunction

endpackage

>>> design/mwts_if.sv
// mwts_if: valid/ready channels for input words and result words
// depends on nothing

interface mwts_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic       auto_enable;

  modport source (output valid, command, hour, minute, second, auto_enable, input ready);
  modport sink   (input valid, command, hour, minute, second, auto_enable, output ready);
endinterface

interface mwts_result_if;
  logic valid;
  logic ready;
  logic output_on;
  logic switched_on;
  logic switched_off;

  modport source (output valid, output_on, switched_on, switched_off, input ready);
  modport sink   (input valid, output_on, switched_on, switched_off, output ready);
endinterface

>>> design/mwts_regs.sv
// mwts_regs: window configuration registers with plain write port
// depends on mwts_pkg

module mwts_regs import mwts_pkg::*; #(
  parameter int WINDOWS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output window_t              win [WINDOWS]
);

  for (genvar i = 0; i < WINDOWS; i++) begin : g_win
    if (i < NUM_REGS) begin : g_reg
      window_t window;
      always_ff @(posedge clk) begin
        if (rst) begin
          window <= '0;
        end else if (wr_en && (wr_index == REG_IDX_W'(i))) begin
          window <= window_t'(wr_data);
        end
      end
      assign win[i] = window;
    end else begin : g_zero
      // no register behind the extra windows
      assign win[i] = '0;
    end
  end

endmodule

>>> design/mwts_sched.sv
// mwts_sched: one-pass schedule evaluation over all windows for one word
// depends on mwts_pkg

module mwts_sched import mwts_pkg::*; #(
  parameter int WINDOWS = 4
) (
  input  logic               command,
  input  tod_t               now,
  input  logic               auto_enable,
  input  logic               state_on,
  input  logic [WINDOWS-1:0] marks,
  input  window_t            win [WINDOWS],
  output flags_t             flags,
  output logic [WINDOWS-1:0] marks_next
);

  logic [WINDOWS-1:0] hit;

  always_comb begin
    for (int i = 0; i < WINDOWS; i++) begin
      hit[i] = in_window(now, win[i].on_time, win[i].off_time);
    end
  end

  always_comb begin
    logic on_v;
    logic son;
    logic soff;
    tod_t a;
    tod_t b;
    on_v       = state_on;
    son        = 1'b0;
    soff       = 1'b0;
    a          = '0;
    b          = '0;
    marks_next = marks;
    if (command == CMD_RESYNC) begin
      for (int i = 0; i < WINDOWS; i++) begin
        marks_next[i] = state_on & hit[i];
      end
    end else if (auto_enable) begin
      // forced off when outside every window
      if (on_v && (hit == '0)) begin
        on_v       = 1'b0;
        soff       = 1'b1;
        marks_next = '0;
      end
      for (int i = 0; i < WINDOWS; i++) begin
        a = win[i].on_time;
        b = win[i].off_time;
        if (win[i].enable) begin
          if (!on_v) begin
            if (!marks_next[i] &&
                ((now > a && b > now && b > a) || (b > now && a > now && a > b))) begin
              on_v          = 1'b1;
              marks_next[i] = 1'b1;
              son           = 1'b1;
            end
          end else begin
            if (marks_next[i] &&
                ((now > b && b > a) || (now > b && a > now && a > b))) begin
              on_v          = 1'b0;
              marks_next[i] = 1'b0;
              soff          = 1'b1;
            end
          end
        end
      end
    end
    flags.output_on    = on_v;
    flags.switched_on  = son;
    flags.switched_off = soff;
  end

endmodule

>>> design/multi_window_time_switch.sv
// multi_window_time_switch: top level, input register, state, result register
// depends on mwts_pkg, mwts_if, mwts_regs, mwts_sched
//
// usage: each word on the item channel carries a time of day, a command and
// an auto flag; the block returns exactly one result word per item word on
// the result channel, carrying the output state and the switch flags.
// windows are programmed through wr_en / wr_index / wr_data, one register
// per window up to NUM_REGS; the user must program them only while the
// block is idle, which the block itself does not enforce. an accepted item
// word loads the input register, then passes once through the window
// compare chain into the result register.
// throughput: one word per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// reset: output off, all window marks and window registers cleared, both
// channels empty.
// stall: when the receiver holds ready low the result word stays put, the
// input register fills, and then item ready drops until the result is taken.

module multi_window_time_switch import mwts_pkg::*; #(
  parameter int WINDOWS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  mwts_item_if.sink            item,
  mwts_result_if.source        result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data
);

  window_t            win [WINDOWS];
  logic               s1_valid;
  logic               s1_command;
  tod_t               s1_now;
  logic               s1_auto;
  logic               advance;
  logic               output_state;
  logic [WINDOWS-1:0] marks;
  logic [WINDOWS-1:0] marks_next;
  flags_t             flags;
  logic               out_valid;
  flags_t             out_flags;

  mwts_regs #(.WINDOWS(WINDOWS)) u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .win      (win)
  );

  mwts_sched #(.WINDOWS(WINDOWS)) u_sched (
    .command     (s1_command),
    .now         (s1_now),
    .auto_enable (s1_auto),
    .state_on    (output_state),
    .marks       (marks),
    .win         (win),
    .flags       (flags),
    .marks_next  (marks_next)
  );

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_command <= item.command;
      s1_now     <= {item.hour, item.minute, item.second};
      s1_auto    <= item.auto_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_state <= 1'b0;
      marks        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        output_state <= flags.output_on;
        marks        <= marks_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_flags <= flags;
    end
  end

  assign result.valid        = out_valid;
  assign result.output_on    = out_flags.output_on;
  assign result.switched_on  = out_flags.switched_on;
  assign result.switched_off = out_flags.switched_off;

  a_resync_no_switch: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_RESYNC) |=> !result.switched_on && !result.switched_off)
    else $error("resync word reported a switch");

  a_tick_idle_state: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_TICK) && !s1_auto
      |=> $stable(output_state) && $stable(marks))
    else $error("tick without auto changed state");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.output_on == output_state))
    else $error("result output differs from held state");

  a_on_then_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.switched_on && !result.output_on |-> result.switched_off)
    else $error("switched on but ended off without off flag");

endmodule
